// ===== hw/rtl/ddft_pkg.sv =====
// shared types, constants and twiddle tables for the direct dft block
package ddft_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int LOG2_MAX    = 6;
    localparam int IDX_BITS    = LOG2_MAX;
    localparam int SAMPLE_BITS = 16;
    localparam int TW_BITS     = 16;
    localparam int PROD_BITS   = SAMPLE_BITS + TW_BITS;
    localparam int ACC_BITS    = PROD_BITS + 1 + LOG2_MAX + 1;
    localparam int OUT_BITS    = 24;
    localparam int SHIFT_BITS  = 5;
    localparam int Q15_SHIFT   = 15;

    // configuration register indexes
    localparam logic [0:0] CFG_INVERSE = 1'd0;
    localparam logic [0:0] CFG_SIZE    = 1'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] bin_re;
        logic signed [OUT_BITS-1:0] bin_im;
        logic [IDX_BITS-1:0]        bin_index;
        logic                       last_bin;
    } t_out_item;

    typedef logic signed [TW_BITS-1:0] t_tw_tab [0:MAX_POINTS-1];

    // q15 of sin(pi/2 * a / MAX_POINTS), odd taylor series in unsigned q30
    function automatic logic [TW_BITS-1:0] f_sin_quarter(input int unsigned a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        int          i;
        x    = (64'd1686629713 * 64'(a)) / MAX_POINTS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (i = 1; i <= 5; i++) begin
            term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[TW_BITS-1:0];
    endfunction

    // sin(pi/2 * r / MAX_POINTS) over all four quadrants
    function automatic logic signed [TW_BITS-1:0] f_wave(input int unsigned r);
        int unsigned rr;
        int unsigned quad;
        int unsigned rem;
        logic [TW_BITS-1:0] v;
        rr   = r % (4 * MAX_POINTS);
        quad = rr / MAX_POINTS;
        rem  = rr % MAX_POINTS;
        if (quad == 0 || quad == 2) begin
            v = f_sin_quarter(rem);
        end else begin
            v = f_sin_quarter(MAX_POINTS - rem);
        end
        if (quad >= 2) begin
            return -$signed(v);
        end
        return $signed(v);
    endfunction

    function automatic t_tw_tab f_cos_tab();
        t_tw_tab t;
        for (int i = 0; i < MAX_POINTS; i++) begin
            t[i] = f_wave(4 * i + MAX_POINTS);
        end
        return t;
    endfunction

    function automatic t_tw_tab f_sin_tab();
        t_tw_tab t;
        for (int i = 0; i < MAX_POINTS; i++) begin
            t[i] = f_wave(4 * i);
        end
        return t;
    endfunction

    localparam t_tw_tab COS_TAB = f_cos_tab();
    localparam t_tw_tab SIN_TAB = f_sin_tab();

endpackage

// ===== hw/rtl/ddft_ram.sv =====
// generic single write port ram with registered read
module ddft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/direct_dft_forward_inverse_top.sv =====
// direct summation dft top level: sample store, shared complex mac, sequencer
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   cfg     | in        | i_cfg_we                | i_cfg_addr, i_cfg_wdata
//   in      | in        | i_in_valid / o_in_stall | i_in_item (t_in_item)
//   out     | out       | o_out_valid/i_out_stall | o_out_item (t_out_item)
//
// samples are taken one a cycle while loading; the item that completes a frame of n
// points starts the transform. each bin runs n products through the single complex mac,
// then drains the pipeline and rounds. no item is accepted while bins are computed.
// a stalled output holds the sequencer at the next bin boundary. reset clears the count
// and the inverse flag and sets the size to the maximum; the store is not cleared.
module direct_dft_forward_inverse_top
    import ddft_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [0:0]      i_cfg_addr,
    input  logic [2:0]      i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_item        i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_item       o_out_item
);

    typedef enum logic [1:0] {S_LOAD, S_MAC, S_FINISH} t_state;

    t_state                      r_state;
    logic                        r_inverse;
    logic [2:0]                  r_size_log2;
    logic [IDX_BITS-1:0]         r_load_cnt;
    logic [IDX_BITS-1:0]         r_bin;
    logic [IDX_BITS-1:0]         r_k;
    logic [IDX_BITS-1:0]         r_phase;
    logic [IDX_BITS-1:0]         r_step;
    logic                        r_out_valid;
    t_out_item                   r_out_item;

    logic                        r_v1;
    logic                        r_v2;
    logic signed [TW_BITS-1:0]   r_cos;
    logic signed [TW_BITS-1:0]   r_sin;
    logic signed [PROD_BITS-1:0] r_p_rc;
    logic signed [PROD_BITS-1:0] r_p_is;
    logic signed [PROD_BITS-1:0] r_p_ic;
    logic signed [PROD_BITS-1:0] r_p_rs;
    logic signed [ACC_BITS-1:0]  r_acc_re;
    logic signed [ACC_BITS-1:0]  r_acc_im;

    logic [2:0]                  w_lg;
    logic [2:0]                  w_shift;
    logic [IDX_BITS-1:0]         w_last_idx;
    logic [IDX_BITS-1:0]         w_next_bin;
    logic                        w_in_accept;
    logic                        w_frame_done;
    logic                        w_size_write;
    logic                        w_emit;
    logic                        w_acc_clr;
    logic [SHIFT_BITS-1:0]       w_sh;
    logic [2*SAMPLE_BITS-1:0]    w_rdata;
    logic signed [SAMPLE_BITS-1:0] w_x_re;
    logic signed [SAMPLE_BITS-1:0] w_x_im;
    logic signed [PROD_BITS:0]   w_term_re;
    logic signed [PROD_BITS:0]   w_term_im;

    // floor((v + half) >> sh), saturated to the output width
    function automatic logic signed [OUT_BITS-1:0] f_round_sat(
        input logic signed [ACC_BITS-1:0]   v,
        input logic [SHIFT_BITS-1:0]        sh
    );
        logic signed [ACC_BITS:0] sum;
        logic signed [ACC_BITS:0] q;
        sum = (ACC_BITS+1)'(v) + ((ACC_BITS+1)'(1) <<< (sh - SHIFT_BITS'(1)));
        q   = sum >>> sh;
        if (q > (ACC_BITS+1)'((1 <<< (OUT_BITS - 1)) - 1)) begin
            return {1'b0, {(OUT_BITS-1){1'b1}}};
        end else if (q < -(ACC_BITS+1)'(1 <<< (OUT_BITS - 1))) begin
            return {1'b1, {(OUT_BITS-1){1'b0}}};
        end
        return q[OUT_BITS-1:0];
    endfunction

    // size register clamped to the supported range
    always_comb begin
        if (r_size_log2 == 3'd0) begin
            w_lg = 3'd1;
        end else if (r_size_log2 > 3'(LOG2_MAX)) begin
            w_lg = 3'(LOG2_MAX);
        end else begin
            w_lg = r_size_log2;
        end
    end

    assign w_shift      = 3'(LOG2_MAX) - w_lg;
    assign w_last_idx   = IDX_BITS'(((IDX_BITS+1)'(1) << w_lg) - (IDX_BITS+1)'(1));
    assign w_next_bin   = r_bin + IDX_BITS'(1);
    assign w_in_accept  = i_in_valid && (r_state == S_LOAD);
    assign w_frame_done = w_in_accept && (r_load_cnt == w_last_idx);
    assign w_size_write = i_cfg_we && (i_cfg_addr == CFG_SIZE);
    assign w_emit       = (r_state == S_FINISH) && !r_v1 && !r_v2
                          && (!r_out_valid || !i_out_stall);
    assign w_acc_clr    = w_emit || w_frame_done;
    assign w_sh         = SHIFT_BITS'(Q15_SHIFT) + (r_inverse ? SHIFT_BITS'(w_lg)
                                                              : SHIFT_BITS'(0));

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ddft_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_accept),
        .i_waddr (r_load_cnt),
        .i_wdata ({i_in_item.sample_re, i_in_item.sample_im}),
        .i_raddr (r_k),
        .o_rdata (w_rdata)
    );

    assign w_x_re = $signed(w_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign w_x_im = $signed(w_rdata[SAMPLE_BITS-1:0]);

    // forward uses w = cos - j sin, inverse uses cos + j sin
    always_comb begin
        if (r_inverse) begin
            w_term_re = (PROD_BITS+1)'(r_p_rc) - (PROD_BITS+1)'(r_p_is);
            w_term_im = (PROD_BITS+1)'(r_p_ic) + (PROD_BITS+1)'(r_p_rs);
        end else begin
            w_term_re = (PROD_BITS+1)'(r_p_rc) + (PROD_BITS+1)'(r_p_is);
            w_term_im = (PROD_BITS+1)'(r_p_ic) - (PROD_BITS+1)'(r_p_rs);
        end
    end

    // mac pipeline: twiddle fetch, products, accumulate
    always_ff @(posedge i_clk) begin
        r_cos  <= COS_TAB[r_phase];
        r_sin  <= SIN_TAB[r_phase];
        r_p_rc <= w_x_re * r_cos;
        r_p_is <= w_x_im * r_sin;
        r_p_ic <= w_x_im * r_cos;
        r_p_rs <= w_x_re * r_sin;
        if (w_acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + ACC_BITS'(w_term_re);
            r_acc_im <= r_acc_im + ACC_BITS'(w_term_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_inverse   <= 1'b0;
            r_size_log2 <= 3'(LOG2_MAX);
            r_load_cnt  <= '0;
            r_bin       <= '0;
            r_k         <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_MAC);
            r_v2 <= r_v1;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // a size write drops any partial frame
            if (w_size_write || w_frame_done) begin
                r_load_cnt <= '0;
            end else if (w_in_accept) begin
                r_load_cnt <= r_load_cnt + IDX_BITS'(1);
            end
            case (r_state)
                S_LOAD: begin
                    if (w_frame_done) begin
                        r_bin   <= '0;
                        r_k     <= '0;
                        r_phase <= '0;
                        r_step  <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_k     <= r_k + IDX_BITS'(1);
                    // phase wraps at the table length, which is bin*k mod n scaled up
                    r_phase <= r_phase + r_step;
                    if (r_k == w_last_idx) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_emit) begin
                        r_out_item.bin_re    <= f_round_sat(r_acc_re, w_sh);
                        r_out_item.bin_im    <= f_round_sat(r_acc_im, w_sh);
                        r_out_item.bin_index <= r_bin;
                        r_out_item.last_bin  <= (r_bin == w_last_idx);
                        if (r_bin == w_last_idx) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_bin   <= w_next_bin;
                            r_k     <= '0;
                            r_phase <= '0;
                            r_step  <= w_next_bin << w_shift;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_INVERSE: begin
                        r_inverse <= i_cfg_wdata[0];
                    end
                    CFG_SIZE: begin
                        r_size_log2 <= i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_load_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (!r_v1 && !r_v2))
        else $error("mac pipeline busy while loading samples");

    a_load_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_load_cnt <= w_last_idx))
        else $error("load count beyond frame length");

    a_emit_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("bin presented outside the finish step");
`endif

endmodule
